@@ sv/bpc_pkg.sv @@
// shared types and constants for the button press classifier
package bpc_pkg;

  // widths of the configuration registers and the payload
  localparam int unsigned INTERVAL_W = 10;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned KIND_W     = 2;

  // register reset values
  localparam logic [INTERVAL_W-1:0] RST_SAMPLE_INTERVAL = 10'd5;
  localparam logic [MS_W-1:0]       RST_DEBOUNCE        = 16'd50;
  localparam logic [MS_W-1:0]       RST_WINDOW          = 16'd500;
  localparam logic [MS_W-1:0]       RST_LONG_PRESS      = 16'd1000;
  localparam logic                  RST_ACTIVE_HIGH     = 1'b1;

  // press counter saturates here
  localparam logic [COUNT_W-1:0] PRESS_MAX = 8'hff;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_INTERVAL = 3'd0,
    CFG_DEBOUNCE        = 3'd1,
    CFG_WINDOW          = 3'd2,
    CFG_LONG_PRESS      = 3'd3,
    CFG_ACTIVE_HIGH     = 3'd4
  } cfg_idx_t;

  // reported event
  typedef enum logic [KIND_W-1:0] {
    EV_NONE  = 2'd0,
    EV_MULTI = 2'd1,
    EV_LONG  = 2'd2
  } event_kind_t;

  // configuration as seen by the classifier core
  typedef struct packed {
    logic [INTERVAL_W-1:0] sample_interval;
    logic [MS_W-1:0]       debounce;
    logic [MS_W-1:0]       window;
    logic [MS_W-1:0]       long_press;
    logic                  active_high;
  } cfg_t;

  // result of one tick
  typedef struct packed {
    event_kind_t        kind;
    logic [COUNT_W-1:0] press_count;
    logic               busy;
  } res_t;

endpackage

@@ sv/bpc_core.sv @@
// classifier state and per-tick next-state logic
module bpc_core #(
  parameter int unsigned HISTORY_BITS   = 16,
  parameter int unsigned MAJORITY_ABOVE = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bpc_pkg::cfg_t cfg,
  input  logic          step_en,
  input  logic          pin_level,
  output bpc_pkg::res_t res
);

  localparam int unsigned CNT_W = $clog2(HISTORY_BITS + 1);

  logic                        polling_r,   polling_nxt;
  logic [HISTORY_BITS-1:0]     hist_r,      hist_nxt;
  logic [CNT_W-1:0]            ones_r,      ones_nxt;
  logic                        deb_r,       deb_nxt;
  logic [bpc_pkg::COUNT_W-1:0] presses_r,   presses_nxt;
  logic [bpc_pkg::TIME_W-1:0]  now_r,       now_nxt;
  logic [bpc_pkg::TIME_W-1:0]  last_smp_r,  last_smp_nxt;
  logic [bpc_pkg::TIME_W-1:0]  last_chg_r,  last_chg_nxt;
  logic                        prev_act_r,  prev_act_nxt;

  logic                        active;
  logic [bpc_pkg::TIME_W-1:0]  since_smp;
  logic [bpc_pkg::TIME_W-1:0]  elapsed;
  logic [CNT_W-1:0]            shift_ones;
  logic                        pressed;

  // pin level mapped to pressed polarity
  assign active = (pin_level == cfg.active_high);

  // time differences wrap modulo 2^32
  assign since_smp = now_r - last_smp_r;
  assign elapsed   = now_r - last_chg_r;

  // running count of ones in the history after a shift
  assign shift_ones = ones_r + CNT_W'(active) - CNT_W'(hist_r[HISTORY_BITS-1]);
  assign pressed    = 32'(shift_ones) > 32'(MAJORITY_ABOVE);

  // next state for one tick
  always_comb begin
    polling_nxt  = polling_r;
    hist_nxt     = hist_r;
    ones_nxt     = ones_r;
    deb_nxt      = deb_r;
    presses_nxt  = presses_r;
    last_smp_nxt = last_smp_r;
    last_chg_nxt = last_chg_r;
    prev_act_nxt = active;
    now_nxt      = now_r + 32'd1;
    res.kind        = bpc_pkg::EV_NONE;
    res.press_count = '0;
    if (!polling_r) begin
      if (active && !prev_act_r) begin
        polling_nxt  = 1'b1;
        hist_nxt     = '1;
        ones_nxt     = CNT_W'(HISTORY_BITS);
        deb_nxt      = 1'b1;
        last_chg_nxt = now_r;
        last_smp_nxt = now_r;
        presses_nxt  = '0;
      end
    end else if (since_smp >= 32'(cfg.sample_interval)) begin
      last_smp_nxt = now_r;
      hist_nxt     = {hist_r[HISTORY_BITS-2:0], active};
      ones_nxt     = shift_ones;
      if (!pressed && deb_r) begin
        // debounced release
        if (elapsed >= 32'(cfg.debounce)) begin
          if (presses_r != bpc_pkg::PRESS_MAX) begin
            presses_nxt = presses_r + 8'd1;
          end
          last_chg_nxt = now_r;
        end
        deb_nxt = 1'b0;
      end else if (!pressed) begin
        // idle gap ends the run
        if (elapsed >= 32'(cfg.window)) begin
          if (presses_r != '0) begin
            res.kind        = bpc_pkg::EV_MULTI;
            res.press_count = presses_r;
            presses_nxt     = '0;
          end
          polling_nxt = 1'b0;
        end
      end else begin
        // held down
        if (elapsed >= 32'(cfg.long_press) && presses_r == '0) begin
          res.kind    = bpc_pkg::EV_LONG;
          polling_nxt = 1'b0;
        end
        deb_nxt = 1'b1;
      end
    end
    res.busy = polling_nxt;
  end

  // state registers, updated once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      polling_r  <= 1'b0;
      hist_r     <= '0;
      ones_r     <= '0;
      deb_r      <= 1'b0;
      presses_r  <= '0;
      now_r      <= '0;
      last_smp_r <= '0;
      last_chg_r <= '0;
      prev_act_r <= 1'b0;
    end else if (step_en) begin
      polling_r  <= polling_nxt;
      hist_r     <= hist_nxt;
      ones_r     <= ones_nxt;
      deb_r      <= deb_nxt;
      presses_r  <= presses_nxt;
      now_r      <= now_nxt;
      last_smp_r <= last_smp_nxt;
      last_chg_r <= last_chg_nxt;
      prev_act_r <= prev_act_nxt;
    end
  end

endmodule

@@ sv/button_press_classifier.sv @@
// top level of the button press classifier: ports, registers and pipeline
//
// Usage: feed one raw pin sample per millisecond tick on the in_ stream
// (in_tdata bit 0). Every tick produces exactly one result transaction on
// the out_ stream: out_tuser carries the event kind (none, multi-press
// report, long press), out_tdata carries the press count and the busy flag.
// Settings are written through cfg_wr_en / cfg_index / cfg_data while the
// block is idle; indexes past the register list are ignored.
// Path: a tick accepted into the input register is classified and captured in
// the result register when it advances, and is shown on the out_ ports from then on.
// Throughput: one tick per cycle while out_tready is high; the input register and the result
// register form a two-stage pipeline, so a new tick is taken while a
// finished result waits on the output.
// Stall: when out_tready is low with a result pending, the input register
// holds its tick and in_tready drops once it is full; nothing is lost.
// Reset (synchronous, rst_n low) empties both stages, clears the classifier
// state and loads the default settings.
module button_press_classifier #(
  parameter int unsigned HISTORY_BITS   = 16,
  parameter int unsigned MAJORITY_ABOVE = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bpc_pkg::IN_DATA_W-1:0]       in_tdata,   // [0] pin_level
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bpc_pkg::OUT_DATA_W-1:0]      out_tdata,  // [7:0] press_count, [8] busy_res
  output logic [bpc_pkg::KIND_W-1:0]          out_tuser,  // [1:0] event_kind
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  bpc_pkg::cfg_t cfg_r;
  logic          s0_valid_r, s0_valid_nxt;
  logic          s0_pin_r;
  logic          out_valid_r, out_valid_nxt;
  bpc_pkg::res_t out_res_r;
  bpc_pkg::res_t res;
  logic          in_accept;
  logic          advance;

  // handshake and pipeline advance
  assign advance   = s0_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s0_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    s0_valid_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : s0_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_interval <= bpc_pkg::RST_SAMPLE_INTERVAL;
      cfg_r.debounce        <= bpc_pkg::RST_DEBOUNCE;
      cfg_r.window          <= bpc_pkg::RST_WINDOW;
      cfg_r.long_press      <= bpc_pkg::RST_LONG_PRESS;
      cfg_r.active_high     <= bpc_pkg::RST_ACTIVE_HIGH;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bpc_pkg::CFG_SAMPLE_INTERVAL: cfg_r.sample_interval <= cfg_data[bpc_pkg::INTERVAL_W-1:0];
        bpc_pkg::CFG_DEBOUNCE:        cfg_r.debounce        <= cfg_data[bpc_pkg::MS_W-1:0];
        bpc_pkg::CFG_WINDOW:          cfg_r.window          <= cfg_data[bpc_pkg::MS_W-1:0];
        bpc_pkg::CFG_LONG_PRESS:      cfg_r.long_press      <= cfg_data[bpc_pkg::MS_W-1:0];
        bpc_pkg::CFG_ACTIVE_HIGH:     cfg_r.active_high     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
    end
    if (in_accept) begin
      s0_pin_r <= in_tdata[0];
    end
  end

  // classifier core
  bpc_core #(
    .HISTORY_BITS   (HISTORY_BITS),
    .MAJORITY_ABOVE (MAJORITY_ABOVE)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step_en   (advance),
    .pin_level (s0_pin_r),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {{(bpc_pkg::OUT_DATA_W - bpc_pkg::COUNT_W - 1){1'b0}},
                       out_res_r.busy, out_res_r.press_count};

  // a reported event always ends polling
  a_event_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.kind != bpc_pkg::EV_NONE |-> !out_res_r.busy)
    else $error("event reported while still polling");

  // a press count only travels with a multi-press report
  a_count_only_multi: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.kind != bpc_pkg::EV_MULTI |-> out_res_r.press_count == '0)
    else $error("press count without multi-press report");

  // a multi-press report never carries zero presses
  a_multi_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.kind == bpc_pkg::EV_MULTI |-> out_res_r.press_count != '0)
    else $error("multi-press report with zero presses");

  // a tick moved through the core shows up as a result in the next cycle
  a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("classified tick produced no result");

endmodule

@@ bench/tb_top.sv @@
// self-checking testbench for the button press classifier
module tb_top;

  localparam int HIST_BITS      = 16;
  localparam int MAJORITY       = 12;
  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_PHASES  = 4;
  localparam int PHASE_TICKS    = 85;
  localparam longint LIMIT_CYCLES = 2000000;

  // first register index past the list, writes there must be ignored
  localparam int CFG_PAST_END = int'(bpc_pkg::CFG_ACTIVE_HIGH) + 1;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_op_t;

  typedef struct packed {
    row_op_t                        op;
    logic                           pin;
    logic [bpc_pkg::CFG_IDX_W-1:0]  idx;
    logic [bpc_pkg::CFG_DATA_W-1:0] data;
    logic                           typed;
    bpc_pkg::res_t                  want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [bpc_pkg::IN_DATA_W-1:0] in_tdata;    // [0] pin_level
  logic out_tvalid;
  logic out_tready;
  logic [bpc_pkg::OUT_DATA_W-1:0] out_tdata;  // [7:0] press_count, [8] busy_res
  logic [bpc_pkg::KIND_W-1:0] out_tuser;      // [1:0] event_kind
  logic cfg_wr_en;
  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data;

  // predictor copy of the settings
  logic [bpc_pkg::INTERVAL_W-1:0] cf_interval;
  logic [bpc_pkg::MS_W-1:0]       cf_debounce;
  logic [bpc_pkg::MS_W-1:0]       cf_window;
  logic [bpc_pkg::MS_W-1:0]       cf_long;
  logic                           cf_active_high;

  // predictor copy of the classifier state
  logic                          st_polling;
  logic [HIST_BITS-1:0]          st_history;
  logic                          st_debounced;
  logic [bpc_pkg::COUNT_W-1:0]   st_presses;
  logic [bpc_pkg::TIME_W-1:0]    st_now;
  logic [bpc_pkg::TIME_W-1:0]    st_last_sample;
  logic [bpc_pkg::TIME_W-1:0]    st_last_change;
  logic                          st_prev_active;

  bpc_pkg::res_t expected_events[$];
  row_t stim_rows[$];

  logic send_idle;
  logic sink_idle;
  logic sink_hold;
  int   fails;
  int   ticks_sent;
  int   results_checked;
  int   multi_seen;
  int   long_seen;

  button_press_classifier #(
    .HISTORY_BITS   (HIST_BITS),
    .MAJORITY_ABOVE (MAJORITY)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor: defaults after reset
  task automatic model_reset();
    cf_interval    = bpc_pkg::RST_SAMPLE_INTERVAL;
    cf_debounce    = bpc_pkg::RST_DEBOUNCE;
    cf_window      = bpc_pkg::RST_WINDOW;
    cf_long        = bpc_pkg::RST_LONG_PRESS;
    cf_active_high = bpc_pkg::RST_ACTIVE_HIGH;
    st_polling     = 1'b0;
    st_history     = '0;
    st_debounced   = 1'b0;
    st_presses     = '0;
    st_now         = '0;
    st_last_sample = '0;
    st_last_change = '0;
    st_prev_active = 1'b0;
  endtask

  // predictor: register write, unknown indexes do nothing
  function automatic void apply_reg(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [bpc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      bpc_pkg::CFG_SAMPLE_INTERVAL: cf_interval = data[bpc_pkg::INTERVAL_W-1:0];
      bpc_pkg::CFG_DEBOUNCE:        cf_debounce = data[bpc_pkg::MS_W-1:0];
      bpc_pkg::CFG_WINDOW:          cf_window = data[bpc_pkg::MS_W-1:0];
      bpc_pkg::CFG_LONG_PRESS:      cf_long = data[bpc_pkg::MS_W-1:0];
      bpc_pkg::CFG_ACTIVE_HIGH:     cf_active_high = data[0];
      default: ;
    endcase
  endfunction

  // predictor: one millisecond tick, returns the result it causes
  function automatic bpc_pkg::res_t classify_tick(input logic pin);
    bpc_pkg::res_t r;
    logic act;
    logic held;
    logic [bpc_pkg::TIME_W-1:0] t;
    logic [bpc_pkg::TIME_W-1:0] since_sample;
    logic [bpc_pkg::TIME_W-1:0] elapsed;
    t = st_now;
    act = (pin == cf_active_high);
    r.kind = bpc_pkg::EV_NONE;
    r.press_count = '0;
    since_sample = t - st_last_sample;
    if (!st_polling) begin
      // inactive-to-active edge starts polling without a sample
      if (act && !st_prev_active) begin
        st_polling     = 1'b1;
        st_history     = '1;
        st_debounced   = 1'b1;
        st_last_change = t;
        st_last_sample = t;
        st_presses     = '0;
      end
    end else if (since_sample >= bpc_pkg::TIME_W'(cf_interval)) begin
      st_last_sample = t;
      st_history = {st_history[HIST_BITS-2:0], act};
      held = ($countones(st_history) > MAJORITY);
      elapsed = t - st_last_change;
      if (!held && st_debounced) begin
        // release, counted once debounced
        if (elapsed >= bpc_pkg::TIME_W'(cf_debounce)) begin
          if (st_presses != bpc_pkg::PRESS_MAX) st_presses = st_presses + 1'b1;
          st_last_change = t;
        end
        st_debounced = 1'b0;
      end else if (!held) begin
        // idle gap past the window ends polling
        if (elapsed >= bpc_pkg::TIME_W'(cf_window)) begin
          if (st_presses != '0) begin
            r.kind = bpc_pkg::EV_MULTI;
            r.press_count = st_presses;
            st_presses = '0;
          end
          st_polling = 1'b0;
        end
      end else begin
        if (elapsed >= bpc_pkg::TIME_W'(cf_long) && st_presses == '0) begin
          r.kind = bpc_pkg::EV_LONG;
          st_polling = 1'b0;
        end
        st_debounced = 1'b1;
      end
    end
    st_prev_active = act;
    st_now = t + 1'b1;
    r.busy = st_polling;
    return r;
  endfunction

  // random idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // directed table entries
  function automatic void add_tick(input logic pin);
    row_t r;
    r = '0;
    r.op = ROW_TICK;
    r.pin = pin;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  function automatic void add_tick_exp(input logic pin, input bpc_pkg::event_kind_t k,
                                       input logic [bpc_pkg::COUNT_W-1:0] c,
                                       input logic b);
    row_t r;
    r = '0;
    r.op = ROW_TICK;
    r.pin = pin;
    r.typed = 1'b1;
    r.want.kind = k;
    r.want.press_count = c;
    r.want.busy = b;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  function automatic void add_write(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [bpc_pkg::CFG_DATA_W-1:0] data);
    row_t r;
    r = '0;
    r.op = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  // offer one tick transaction, record its expected result on acceptance
  task automatic send_tick(input logic pin, input logic typed,
                           input bpc_pkg::res_t typed_res);
    int gap;
    bpc_pkg::res_t pred;
    gap = send_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= bpc_pkg::IN_DATA_W'(pin);
    do @(posedge clk); while (!in_tready);
    pred = classify_tick(pin);
    expected_events.insert(expected_events.size(), typed ? typed_res : pred);
    ticks_sent++;
  endtask

  // stop offering and let every pending result come out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write, the caller lowers the enable after a batch
  task automatic write_reg(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bpc_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  // full setting with random junk in the unused data bits
  task automatic set_config(input logic [bpc_pkg::INTERVAL_W-1:0] iv,
                            input logic [bpc_pkg::MS_W-1:0] db,
                            input logic [bpc_pkg::MS_W-1:0] win,
                            input logic [bpc_pkg::MS_W-1:0] lp,
                            input logic ah);
    logic [bpc_pkg::CFG_DATA_W-1:0] pad;
    wait_idle();
    pad = bpc_pkg::CFG_DATA_W'($urandom());
    write_reg(bpc_pkg::CFG_SAMPLE_INTERVAL,
              {pad[bpc_pkg::CFG_DATA_W-1:bpc_pkg::INTERVAL_W], iv});
    write_reg(bpc_pkg::CFG_DEBOUNCE, db);
    write_reg(bpc_pkg::CFG_WINDOW, win);
    write_reg(bpc_pkg::CFG_LONG_PRESS, lp);
    pad = bpc_pkg::CFG_DATA_W'($urandom());
    write_reg(bpc_pkg::CFG_ACTIVE_HIGH, {pad[bpc_pkg::CFG_DATA_W-1:1], ah});
    if ($urandom_range(0, 1) == 1) begin
      for (int i = CFG_PAST_END; i < (1 << bpc_pkg::CFG_IDX_W); i++)
        write_reg(bpc_pkg::CFG_IDX_W'(i), bpc_pkg::CFG_DATA_W'($urandom()));
    end
    cfg_wr_en <= 1'b0;
  endtask

  // hold the button pressed or released, with optional contact bounce
  task automatic hold_level(input logic pressed, input int ticks, input logic noisy);
    logic lvl;
    for (int i = 0; i < ticks; i++) begin
      lvl = pressed;
      if (noisy && $urandom_range(0, 39) == 0) lvl = ~lvl;
      send_tick(lvl ? cf_active_high : ~cf_active_high, 1'b0, '0);
    end
  endtask

  // one user action: multi-press, long hold, noise or a broken press
  task automatic play_gesture(input int spacing);
    int pick;
    logic noisy;
    pick = $urandom_range(0, 99);
    noisy = ($urandom_range(0, 2) == 0);
    hold_level(1'b0, $urandom_range(1, 4) * spacing, 1'b0);
    if (pick < 55) begin
      repeat ($urandom_range(1, 3)) begin
        hold_level(1'b1, $urandom_range(13, 19) * spacing, noisy);
        hold_level(1'b0, $urandom_range(4, 8) * spacing, noisy);
      end
      hold_level(1'b0, int'(cf_window) + 3 * spacing, 1'b0);
    end else if (pick < 75) begin
      hold_level(1'b1, int'(cf_long) + 4 * spacing, noisy);
      hold_level(1'b0, 6 * spacing, 1'b0);
    end else if (pick < 88) begin
      repeat ($urandom_range(5, 30)) send_tick(1'($urandom_range(0, 1)), 1'b0, '0);
    end else begin
      hold_level(1'b1, $urandom_range(2, 12) * spacing, 1'b1);
      hold_level(1'b0, $urandom_range(1, 5) * spacing, 1'b1);
    end
  endtask

  // compare one result transaction with the oldest expectation
  task automatic check_result();
    bpc_pkg::res_t want;
    if (expected_events.size() == 0) begin
      $display("%0t: unexpected result: kind %0d count %0d busy %0d", $realtime,
               out_tuser, out_tdata[bpc_pkg::COUNT_W-1:0], out_tdata[bpc_pkg::COUNT_W]);
      fails++;
    end else begin
      want = expected_events.pop_front();
      results_checked++;
      if (want.kind == bpc_pkg::EV_MULTI) multi_seen++;
      if (want.kind == bpc_pkg::EV_LONG) long_seen++;
      if (out_tuser !== want.kind) begin
        $display("%0t: event_kind expected %0d actual %0d", $realtime, want.kind, out_tuser);
        fails++;
      end
      if (out_tdata[bpc_pkg::COUNT_W-1:0] !== want.press_count) begin
        $display("%0t: press_count expected %0d actual %0d", $realtime,
                 want.press_count, out_tdata[bpc_pkg::COUNT_W-1:0]);
        fails++;
      end
      if (out_tdata[bpc_pkg::COUNT_W] !== want.busy) begin
        $display("%0t: busy_res expected %0d actual %0d", $realtime,
                 want.busy, out_tdata[bpc_pkg::COUNT_W]);
        fails++;
      end
    end
  endtask

  // result side: checks and random back-pressure
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_result();
      if (sink_hold) begin
        sink_hold = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left = sink_idle ? pick_gap() : 0;
      end
    end
  end

  // run limit
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout with %0d results pending", $realtime, expected_events.size());
    $display("[button_press_classifier] ERROR");
    $finish;
  end

  // stimulus sequence
  initial begin : stimulus
    row_t row;
    logic writing;
    logic paused;
    int phase_start;
    int spacing;
    logic [bpc_pkg::INTERVAL_W-1:0] iv;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    send_idle = 1'b1;
    sink_idle = 1'b1;
    sink_hold = 1'b0;
    fails = 0;
    ticks_sent = 0;
    results_checked = 0;
    multi_seen = 0;
    long_seen = 0;
    writing = 1'b0;
    paused = 1'b0;
    model_reset();

    // directed table, defaults after reset first
    add_tick_exp(1'b0, bpc_pkg::EV_NONE, 8'd0, 1'b0);  // no edge, stays idle
    add_tick_exp(1'b1, bpc_pkg::EV_NONE, 8'd0, 1'b1);  // edge starts polling, no sample
    add_tick(1'b0);                                    // edge while polling is ignored
    // lowest settings: sample on every tick
    add_write(bpc_pkg::CFG_SAMPLE_INTERVAL, 16'h0000);
    add_write(bpc_pkg::CFG_DEBOUNCE, 16'h0000);
    add_write(bpc_pkg::CFG_WINDOW, 16'h0000);
    add_write(bpc_pkg::CFG_LONG_PRESS, 16'h0000);
    add_tick_exp(1'b1, bpc_pkg::EV_LONG, 8'd0, 1'b0);  // held, no presses: long press at once
    add_tick_exp(1'b1, bpc_pkg::EV_NONE, 8'd0, 1'b0);  // still held: needs a new edge
    // one counted press then the window closes
    add_write(bpc_pkg::CFG_LONG_PRESS, 16'hffff);
    add_tick(1'b0);
    add_tick(1'b1);
    repeat (5) add_tick(1'b0);
    // release too soon to count, polling ends without a report
    add_write(bpc_pkg::CFG_DEBOUNCE, 16'hffff);
    add_tick(1'b1);
    repeat (5) add_tick(1'b0);
    // pressed button reads low
    add_write(bpc_pkg::CFG_ACTIVE_HIGH, 16'h0000);
    add_tick(1'b1);
    add_tick(1'b0);
    // indexes past the register list
    for (int i = CFG_PAST_END; i < (1 << bpc_pkg::CFG_IDX_W); i++)
      add_write(bpc_pkg::CFG_IDX_W'(i), 16'hffff);
    add_tick(1'b0);
    add_tick(1'b1);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.op == ROW_WRITE) begin
        if (!writing) wait_idle();
        write_reg(row.idx, row.data);
        writing = 1'b1;
      end else begin
        if (writing) cfg_wr_en <= 1'b0;
        writing = 1'b0;
        send_tick(row.pin, row.typed, row.want);
      end
    end

    // random gestures under several settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      iv = bpc_pkg::INTERVAL_W'($urandom_range(0, 2));
      spacing = (iv == 0) ? 1 : int'(iv);
      set_config(iv, bpc_pkg::MS_W'($urandom_range(0, 30)),
                 bpc_pkg::MS_W'($urandom_range(20, 80)),
                 bpc_pkg::MS_W'($urandom_range(30, 150)), p[0]);
      send_idle = (p != 0) && (p != 1) && ($urandom_range(0, 3) != 0);
      sink_idle = (p != 0) && ($urandom_range(0, 3) != 0);
      // receiver holds off while ticks keep coming
      if (p == 1) sink_hold = 1'b1;
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < PHASE_TICKS) begin
        play_gesture(spacing);
        // sender waits for every result once, mid-phase
        if (p == 2 && !paused && ticks_sent - phase_start >= PHASE_TICKS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
    end

    // highest settings
    set_config('1, '1, '1, '1, 1'b1);
    send_idle = 1'b1;
    sink_idle = 1'b1;
    repeat (30) send_tick(1'($urandom_range(0, 1)), 1'b0, '0);

    // drain and report
    wait_idle();
    $display("ticks sent %0d, results checked %0d, under %0d random settings",
             ticks_sent, results_checked, RANDOM_PHASES + 1);
    $display("multi-press reports %0d, long presses %0d", multi_seen, long_seen);
    if (fails == 0) begin
      $display("[button_press_classifier] OK");
    end else begin
      $display("[button_press_classifier] ERROR");
    end
    $finish;
  end

endmodule
